// ===== rtl/lru_pr_pkg.sv =====
// ----------------------------------------------------------------------------
// lru_pr_pkg
// Shared codes and defaults for the LRU page replacer with pin flags.
// ----------------------------------------------------------------------------
package lru_pr_pkg;

  // capacity register width and reset value
  localparam int CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // default build sizes
  localparam int DEPTH_DEFAULT    = 16;
  localparam int ID_WIDTH_DEFAULT = 32;

  // request commands
  typedef enum logic [1:0] {
    CMD_TOUCH    = 2'd0,
    CMD_EVICT    = 2'd1,
    CMD_SET_PIN  = 2'd2,
    CMD_RESERVED = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_HIT         = 3'd0,
    ST_INS_FREE    = 3'd1,
    ST_INS_REPLACE = 3'd2,
    ST_REFUSED     = 3'd3,
    ST_EVICTED     = 3'd4,
    ST_EVICT_MISS  = 3'd5,
    ST_PIN_SET     = 3'd6,
    ST_PIN_MISS    = 3'd7
  } status_t;

endpackage

// ===== rtl/lru_page_replacer_with_pins_unit.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacer_with_pins_unit
// LRU page replacer: keeps up to capacity page ids with recency ranks and pin
// flags in one slot memory; touch/insert, evict and set-pin requests.
// ----------------------------------------------------------------------------
// Requests (in_valid / in_stall): command, page_id, pin_value; a word is taken
// when in_valid is high and in_stall is low. Results (out_valid / out_stall):
// status, slot, victim_valid, victim_page_id, one word per request, in order.
// Config (cfg_valid / cfg_ready, always ready): cfg_data is the capacity;
// write it only while no request is in flight.
// Each request walks the slot memory once, one slot per cycle through its
// single read port, then passes the drain and decide states before its
// result word is registered; no new request is taken until the block is
// back in idle. The age/pin update of a request is written back during the
// walk of the next request.
// Reset: all slots invalid, capacity 16. The slot memory is not cleared;
// its contents count only once a slot has been filled.
// Stall: a result word holds while out_stall is high. The next request may
// still be accepted and walked; it waits before its result is registered.
// ----------------------------------------------------------------------------
module lru_page_replacer_with_pins_unit
  import lru_pr_pkg::*;
#(
  parameter int DEPTH    = DEPTH_DEFAULT,
  parameter int ID_WIDTH = ID_WIDTH_DEFAULT,
  localparam int SLOT_W  = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  // config
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [CAP_W-1:0]    cfg_data,
  // requests
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          command,
  input  logic [ID_WIDTH-1:0] page_id,
  input  logic                pin_value,
  // results
  output logic                out_valid,
  input  logic                out_stall,
  output logic [2:0]          status,
  output logic [SLOT_W-1:0]   slot,
  output logic                victim_valid,
  output logic [ID_WIDTH-1:0] victim_page_id
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(DEPTH - 1);

  typedef struct packed {
    logic [ID_WIDTH-1:0] page;
    logic                pinned;
    logic [SLOT_W-1:0]   age;
  } entry_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DECIDE
  } state_t;

  // deferred write-back applied during the next walk
  typedef enum logic [1:0] {
    OP_NONE,
    OP_PROMOTE,
    OP_DEMOTE,
    OP_PIN
  } op_t;

  state_t              state;
  logic [CAP_W-1:0]    capacity;
  logic [DEPTH-1:0]    valid_bits;
  logic [CNT_W-1:0]    cnt;

  // captured request
  cmd_t                req_cmd;
  logic [ID_WIDTH-1:0] req_page;
  logic                req_pin;

  // walk
  logic [SLOT_W-1:0]   rd_idx;
  logic                chk_vld;
  logic [SLOT_W-1:0]   chk_idx;
  entry_t              rd_data;
  entry_t              xf;
  logic                chk_valid_bit;

  // search results
  logic                match_found;
  logic [SLOT_W-1:0]   match_idx;
  logic [SLOT_W-1:0]   match_age;
  logic                free_found;
  logic [SLOT_W-1:0]   free_idx;
  logic                vic_found;
  logic [SLOT_W-1:0]   vic_idx;
  logic [SLOT_W-1:0]   vic_age;
  logic [ID_WIDTH-1:0] vic_page;

  // pending update
  op_t                 pend_op;
  logic [SLOT_W-1:0]   pend_age;
  logic [SLOT_W-1:0]   pend_slot;
  logic                pend_load;
  logic [ID_WIDTH-1:0] pend_page;
  logic                pend_pin;

  // result register
  status_t             out_status;

  // slot memory
  entry_t              mem [DEPTH];

  logic [CMP_W-1:0]    cap_ext;
  logic [CMP_W-1:0]    cap_eff;
  logic                has_room;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign status    = out_status;

  // effective capacity, clamped to 1..DEPTH
  always_comb begin
    cap_ext = CMP_W'(capacity);
    if (cap_ext == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_ext > CMP_W'(DEPTH)) begin
      cap_eff = CMP_W'(DEPTH);
    end else begin
      cap_eff = cap_ext;
    end
    has_room = (CMP_W'(cnt) < cap_eff);
  end

  // apply the previous request's update to the slot just read
  always_comb begin
    chk_valid_bit = valid_bits[chk_idx];
    xf = rd_data;
    case (pend_op)
      OP_PROMOTE: begin
        if (chk_idx == pend_slot) begin
          xf.age = '0;
          if (pend_load) begin
            xf.page   = pend_page;
            xf.pinned = pend_pin;
          end
        end else if (chk_valid_bit && rd_data.age < pend_age) begin
          xf.age = rd_data.age + SLOT_W'(1);
        end
      end
      OP_DEMOTE: begin
        if (chk_idx != pend_slot && chk_valid_bit && rd_data.age > pend_age) begin
          xf.age = rd_data.age - SLOT_W'(1);
        end
      end
      OP_PIN: begin
        if (chk_idx == pend_slot) begin
          xf.pinned = pend_pin;
        end
      end
      default: begin
        xf = rd_data;
      end
    endcase
  end

  // slot memory: one read, one write-back a cycle
  always_ff @(posedge clk) begin
    if (state == S_SCAN) begin
      rd_data <= mem[rd_idx];
    end
    if (chk_vld) begin
      mem[chk_idx] <= xf;
    end
  end

  // control, search and result
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      capacity    <= CAP_RESET;
      valid_bits  <= '0;
      cnt         <= '0;
      chk_vld     <= 1'b0;
      pend_op     <= OP_NONE;
      out_valid   <= 1'b0;
      match_found <= 1'b0;
      free_found  <= 1'b0;
      vic_found   <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        capacity <= cfg_data;
      end

      chk_vld <= (state == S_SCAN);
      chk_idx <= rd_idx;

      // fold the checked slot into the search
      if (chk_vld) begin
        if (chk_valid_bit && xf.page == req_page && !match_found) begin
          match_found <= 1'b1;
          match_idx   <= chk_idx;
          match_age   <= xf.age;
        end
        if (!chk_valid_bit && !free_found) begin
          free_found <= 1'b1;
          free_idx   <= chk_idx;
        end
        if (chk_valid_bit && !xf.pinned && (!vic_found || xf.age > vic_age)) begin
          vic_found <= 1'b1;
          vic_idx   <= chk_idx;
          vic_age   <= xf.age;
          vic_page  <= xf.page;
        end
      end

      // result taken; in S_DECIDE the next word replaces it
      if (out_valid && !out_stall && state != S_DECIDE) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            req_cmd     <= cmd_t'(command);
            req_page    <= page_id;
            req_pin     <= pin_value;
            match_found <= 1'b0;
            free_found  <= 1'b0;
            vic_found   <= 1'b0;
            rd_idx      <= '0;
            state       <= S_SCAN;
          end
        end
        S_SCAN: begin
          rd_idx <= rd_idx + SLOT_W'(1);
          if (rd_idx == LAST_SLOT) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // last slot written back: the old update is fully applied
          pend_op <= OP_NONE;
          state   <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!out_valid || !out_stall) begin
            out_valid      <= 1'b1;
            slot           <= '0;
            victim_valid   <= 1'b0;
            victim_page_id <= '0;
            out_status     <= ST_PIN_MISS;
            pend_load      <= 1'b0;
            pend_page      <= req_page;
            pend_pin       <= req_pin;
            state          <= S_IDLE;
            case (req_cmd)
              CMD_TOUCH: begin
                if (match_found) begin
                  out_status <= ST_HIT;
                  slot       <= match_idx;
                  pend_op    <= OP_PROMOTE;
                  pend_age   <= match_age;
                  pend_slot  <= match_idx;
                end else if (has_room) begin
                  if (free_found) begin
                    out_status           <= ST_INS_FREE;
                    slot                 <= free_idx;
                    valid_bits[free_idx] <= 1'b1;
                    cnt                  <= cnt + CNT_W'(1);
                    pend_op              <= OP_PROMOTE;
                    pend_age             <= cnt[SLOT_W-1:0];
                    pend_slot            <= free_idx;
                    pend_load            <= 1'b1;
                  end else begin
                    out_status <= ST_REFUSED;
                  end
                end else if (vic_found) begin
                  out_status     <= ST_INS_REPLACE;
                  slot           <= vic_idx;
                  victim_valid   <= 1'b1;
                  victim_page_id <= vic_page;
                  pend_op        <= OP_PROMOTE;
                  pend_age       <= vic_age;
                  pend_slot      <= vic_idx;
                  pend_load      <= 1'b1;
                end else begin
                  out_status <= ST_REFUSED;
                end
              end
              CMD_EVICT: begin
                if (match_found) begin
                  out_status            <= ST_EVICTED;
                  slot                  <= match_idx;
                  valid_bits[match_idx] <= 1'b0;
                  cnt                   <= cnt - CNT_W'(1);
                  pend_op               <= OP_DEMOTE;
                  pend_age              <= match_age;
                  pend_slot             <= match_idx;
                end else begin
                  out_status <= ST_EVICT_MISS;
                end
              end
              CMD_SET_PIN: begin
                if (match_found) begin
                  out_status <= ST_PIN_SET;
                  slot       <= match_idx;
                  pend_op    <= OP_PIN;
                  pend_slot  <= match_idx;
                end else begin
                  out_status <= ST_PIN_MISS;
                end
              end
              default: begin
                out_status <= ST_PIN_MISS;
              end
            endcase
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // occupancy counter tracks the valid bits
  a_cnt_matches: assert property (@(posedge clk) disable iff (rst)
    CNT_W'($countones(valid_bits)) == cnt)
    else $error("occupancy count out of step with valid bits");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(cnt) <= CMP_W'(DEPTH))
    else $error("occupancy above depth");

  a_victim_only_replace: assert property (@(posedge clk) disable iff (rst)
    out_valid && victim_valid |-> out_status == ST_INS_REPLACE)
    else $error("victim flagged on a non-replacing result");

  a_miss_slot_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == ST_REFUSED || out_status == ST_EVICT_MISS ||
                  out_status == ST_PIN_MISS) |-> slot == '0 && !victim_valid)
    else $error("miss result carries a slot or victim");

  a_no_pending_in_walk_end: assert property (@(posedge clk) disable iff (rst)
    state == S_DECIDE |-> pend_op == OP_NONE)
    else $error("stale update still pending at decision");

endmodule

// ===== tb/lru_page_replacer_with_pins_unit_tb.sv =====
// ----------------------------------------------------------------------------
// lru_page_replacer_with_pins_unit_tb
// Self-checking bench for the LRU page replacer. Requests go in through a
// valid/stall port, and each one is scored against an in-bench LRU model
// that keeps its own slots, ranks, pin flags and capacity. Directed words
// cover every command, the capacity extremes and the all-pinned refusal.
// After that come random phases with small page-id pools, so hits, evicts and
// replacements stay frequent, with random idle bursts on both ports.
// ----------------------------------------------------------------------------
module lru_page_replacer_with_pins_unit_tb;
  import lru_pr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT          = DEPTH_DEFAULT;
  localparam int IDW            = ID_WIDTH_DEFAULT;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    status_t          status;
    logic [3:0]       slot;
    logic             victim_valid;
    logic [IDW-1:0]   victim_page_id;
  } lru_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CAP_W-1:0] cfg_data = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  cmd_t             command = CMD_TOUCH;
  logic [IDW-1:0]   page_id = '0;
  logic             pin_value = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [2:0]       status;
  logic [3:0]       slot;
  logic             victim_valid;
  logic [IDW-1:0]   victim_page_id;

  // bench-side copy of the replacer state
  logic             slot_live [NSLOT];
  logic [IDW-1:0]   slot_id   [NSLOT];
  logic             slot_pin  [NSLOT];
  int unsigned      slot_rank [NSLOT];
  logic [CAP_W-1:0] capacity_q;

  lru_result_t      pending_results[$];
  int               fail_count = 0;
  bit               idle_on = 1'b1;
  int               stall_cnt = 0;
  int               quiet_cycles = 0;

  always #5 clk = ~clk;

  lru_page_replacer_with_pins_unit u_top (
    .clk            (clk),
    .rst            (rst),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .command        (command),
    .page_id        (page_id),
    .pin_value      (pin_value),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .status         (status),
    .slot           (slot),
    .victim_valid   (victim_valid),
    .victim_page_id (victim_page_id)
  );

  // ---------------------------------------------------------------------------
  // LRU model
  // ---------------------------------------------------------------------------
  // invalidate a slot and close the rank gap it leaves
  function automatic void vacate_slot(int s);
    int i;
    int unsigned r;
    r = slot_rank[s];
    slot_live[s] = 1'b0;
    slot_rank[s] = 0;
    for (i = 0; i < NSLOT; i++)
      if (slot_live[i] && slot_rank[i] > r) slot_rank[i]--;
  endfunction

  // fill an empty slot as the most recent entry
  function automatic void occupy_slot(int s, logic [IDW-1:0] id, logic pin);
    int i;
    for (i = 0; i < NSLOT; i++)
      if (slot_live[i]) slot_rank[i]++;
    slot_live[s] = 1'b1;
    slot_id[s]   = id;
    slot_pin[s]  = pin;
    slot_rank[s] = 0;
  endfunction

  function automatic lru_result_t predict_request(cmd_t c, logic [IDW-1:0] id, logic pin);
    lru_result_t r;
    int i, hit_slot, free_slot, victim, used, cap;
    int unsigned r_old;
    r = '{status: ST_PIN_MISS, slot: '0, victim_valid: 1'b0, victim_page_id: '0};
    hit_slot  = -1;
    free_slot = -1;
    used      = 0;
    for (i = 0; i < NSLOT; i++) begin
      if (slot_live[i]) begin
        used++;
        if (hit_slot < 0 && slot_id[i] == id) hit_slot = i;
      end else if (free_slot < 0) begin
        free_slot = i;
      end
    end
    // zero acts as one, anything above the depth as the depth
    cap = int'(capacity_q);
    if (cap == 0) cap = 1;
    if (cap > NSLOT) cap = NSLOT;

    case (c)
      CMD_TOUCH: begin
        if (hit_slot >= 0) begin
          r_old = slot_rank[hit_slot];
          for (i = 0; i < NSLOT; i++)
            if (slot_live[i] && slot_rank[i] < r_old) slot_rank[i]++;
          slot_rank[hit_slot] = 0;
          r.status = ST_HIT;
          r.slot   = 4'(hit_slot);
        end else if (used < cap) begin
          occupy_slot(free_slot, id, pin);
          r.status = ST_INS_FREE;
          r.slot   = 4'(free_slot);
        end else begin
          // oldest unpinned entry, lowest index on a tie
          victim = -1;
          for (i = 0; i < NSLOT; i++)
            if (slot_live[i] && !slot_pin[i] &&
                (victim < 0 || slot_rank[i] > slot_rank[victim]))
              victim = i;
          if (victim < 0) begin
            r.status = ST_REFUSED;
          end else begin
            r.victim_page_id = slot_id[victim];
            r.victim_valid   = 1'b1;
            vacate_slot(victim);
            occupy_slot(victim, id, pin);
            r.status = ST_INS_REPLACE;
            r.slot   = 4'(victim);
          end
        end
      end
      CMD_EVICT: begin
        if (hit_slot >= 0) begin
          vacate_slot(hit_slot);
          r.status = ST_EVICTED;
          r.slot   = 4'(hit_slot);
        end else begin
          r.status = ST_EVICT_MISS;
        end
      end
      CMD_SET_PIN: begin
        if (hit_slot >= 0) begin
          slot_pin[hit_slot] = pin;
          r.status = ST_PIN_SET;
          r.slot   = 4'(hit_slot);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver: optional idle burst, then hold the word until taken
  // ---------------------------------------------------------------------------
  task automatic send_request(cmd_t c, logic [IDW-1:0] id, logic pin);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    command   <= c;
    page_id   <= id;
    pin_value <= pin;
    in_valid  <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(predict_request(c, id, pin));
  endtask

  // drop valid and wait until every result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    capacity_q = value;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result sink: random stall bursts, score each word taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    lru_result_t exp_r, got_r;
    if (rst) begin
      stall_cnt = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got_r = '{status: status_t'(status), slot: slot, victim_valid: victim_valid,
                  victim_page_id: victim_page_id};
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result word: status=%0d slot=%0d vv=%b vid=%h",
                   $time, status, slot, victim_valid, victim_page_id);
          fail_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (got_r !== exp_r) begin
            $display("%0t: mismatch: expected status=%0d slot=%0d vv=%b vid=%h", $time,
                     exp_r.status, exp_r.slot, exp_r.victim_valid, exp_r.victim_page_id);
            $display("%0t:           actual   status=%0d slot=%0d vv=%b vid=%h", $time,
                     status, slot, victim_valid, victim_page_id);
            fail_count++;
          end
        end
      end
      if (stall_cnt != 0) stall_cnt--;
      else if (idle_on && $urandom_range(0, 9) == 0) stall_cnt = $urandom_range(1, 19);
      out_stall <= (stall_cnt != 0);
    end
  end

  // watchdog: too long without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("lru_page_replacer_with_pins_unit_tb failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // every command at full capacity, id extremes, reserved command
  task automatic test_basic_commands();
    send_request(CMD_TOUCH,    32'h0000_0000, 1'b0);
    send_request(CMD_TOUCH,    32'hFFFF_FFFF, 1'b1);
    send_request(CMD_TOUCH,    32'h0000_0000, 1'b1);  // hit, pin ignored
    send_request(CMD_SET_PIN,  32'h0000_0000, 1'b1);
    send_request(CMD_SET_PIN,  32'h1234_5678, 1'b1);  // pin miss
    send_request(CMD_EVICT,    32'hFFFF_FFFF, 1'b0);
    send_request(CMD_EVICT,    32'hFFFF_FFFF, 1'b0);  // evict miss
    send_request(CMD_RESERVED, 32'h0000_0000, 1'b1);
    send_request(CMD_TOUCH,    32'hA5A5_A5A5, 1'b0);  // refills lowest free slot
  endtask

  // capacity below occupancy, all pinned refusal, out-of-range capacity values
  task automatic test_capacity_limits();
    wait_drained();
    write_capacity(5'd1);
    send_request(CMD_TOUCH,   32'h5A5A_5A5A, 1'b0);
    send_request(CMD_SET_PIN, 32'h5A5A_5A5A, 1'b1);
    send_request(CMD_TOUCH,   32'h0000_0011, 1'b0);
    send_request(CMD_EVICT,   32'h0000_0000, 1'b0);
    send_request(CMD_TOUCH,   32'h0000_0022, 1'b1);
    send_request(CMD_SET_PIN, 32'h5A5A_5A5A, 1'b0);
    send_request(CMD_TOUCH,   32'h0000_0022, 1'b1);
    wait_drained();
    write_capacity(5'd0);
    send_request(CMD_TOUCH,   32'h0000_0033, 1'b0);
    send_request(CMD_SET_PIN, 32'h0000_0022, 1'b0);
    send_request(CMD_TOUCH,   32'h0000_0033, 1'b0);
    wait_drained();
    write_capacity(5'd31);
    send_request(CMD_TOUCH,   32'h8000_0000, 1'b1);
    send_request(CMD_TOUCH,   32'h7FFF_FFFF, 1'b0);
    send_request(CMD_TOUCH,   32'h0000_0033, 1'b0);
  endtask

  // one random phase: fixed capacity, small id pool so hits are common
  task automatic test_random_traffic(int n_items, logic [CAP_W-1:0] cap_value);
    logic [IDW-1:0] id_pool[24];
    logic [IDW-1:0] id;
    int             pool_n, k, pick;
    cmd_t           c;
    logic           pin;
    wait_drained();
    write_capacity(cap_value);
    pool_n = $urandom_range(2, 24);
    for (k = 0; k < pool_n; k++) id_pool[k] = $urandom;
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60)      c = CMD_TOUCH;
      else if (pick < 75) c = CMD_EVICT;
      else if (pick < 95) c = CMD_SET_PIN;
      else                c = CMD_RESERVED;
      if ($urandom_range(0, 9) == 0) id = $urandom;
      else                           id = id_pool[$urandom_range(0, pool_n - 1)];
      pin = ($urandom_range(0, 3) == 0);
      send_request(c, id, pin);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    for (int i = 0; i < NSLOT; i++) begin
      slot_live[i] = 1'b0;
      slot_id[i]   = '0;
      slot_pin[i]  = 1'b0;
      slot_rank[i] = 0;
    end
    capacity_q = CAP_RESET;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    test_basic_commands();
    test_capacity_limits();
    test_random_traffic(122, 5'd16);
    test_random_traffic(122, 5'd1);
    test_random_traffic(122, 5'd2);
    test_random_traffic(122, 5'd17);
    test_random_traffic(122, 5'd4);
    test_random_traffic(122, 5'd0);
    test_random_traffic(122, 5'd8);
    // quiet tail: no idling on either side
    idle_on = 1'b0;
    test_random_traffic(122, 5'($urandom_range(0, 31)));

    wait_drained();
    repeat (NSLOT + 8) @(posedge clk);
    if (fail_count == 0)
      $display("lru_page_replacer_with_pins_unit_tb passed");
    else
      $display("lru_page_replacer_with_pins_unit_tb failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/lru_pr_pkg.sv
rtl/lru_page_replacer_with_pins_unit.sv
tb/lru_page_replacer_with_pins_unit_tb.sv
